>>> rtl/prw_pkg.sv
// Shared types and constants of the horizontal Prewitt edge filter.
// Used by prw_edge and prewitt_horizontal_edge_rgb_core.
// Depends on nothing else.
package prw_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 4096;

  localparam int unsigned ImageWidthReset  = 640;
  localparam int unsigned ImageHeightReset = 480;
  localparam int unsigned DimMin           = 3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned OutColW = 10;
  localparam int unsigned OutRowW = 12;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } pix_t;

  localparam int unsigned PixW = $bits(pix_t);

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0]   out_red;
    logic [ChanW-1:0]   out_green;
    logic [ChanW-1:0]   out_blue;
    logic [OutColW-1:0] out_col;
    logic [OutRowW-1:0] out_row;
    logic               run_end;
    logic               frame_end;
  } out_t;

  // Result slots an input transaction can cause, in emission order.
  typedef enum logic [1:0] {
    SLOT_CENTER = 2'd0,  // pixel one row up and one column left
    SLOT_BELOW  = 2'd1,  // bottom border pixel one column left
    SLOT_RIGHT  = 2'd2,  // right border pixel one row up
    SLOT_CORNER = 2'd3   // bottom right pixel of the frame
  } slot_e;

endpackage

>>> rtl/prw_edge.sv
// Combinational Prewitt kernel for one RGB pixel: top row sum minus bottom
// row sum per channel, clamped to 0..255. Depends on prw_pkg.
module prw_edge (
  input  prw_pkg::pix_t top0_i,
  input  prw_pkg::pix_t top1_i,
  input  prw_pkg::pix_t top2_i,
  input  prw_pkg::pix_t bot0_i,
  input  prw_pkg::pix_t bot1_i,
  input  prw_pkg::pix_t bot2_i,
  output prw_pkg::pix_t edge_o
);

  localparam int unsigned SumW = prw_pkg::ChanW + 2;

  function automatic logic [prw_pkg::ChanW-1:0] chan_edge(
    input logic [prw_pkg::ChanW-1:0] a,
    input logic [prw_pkg::ChanW-1:0] b,
    input logic [prw_pkg::ChanW-1:0] c,
    input logic [prw_pkg::ChanW-1:0] d,
    input logic [prw_pkg::ChanW-1:0] e,
    input logic [prw_pkg::ChanW-1:0] f
  );
    logic [SumW-1:0] up;
    logic [SumW-1:0] dn;
    logic [SumW-1:0] diff;
    logic [prw_pkg::ChanW-1:0] res;
    up   = SumW'(a) + SumW'(b) + SumW'(c);
    dn   = SumW'(d) + SumW'(e) + SumW'(f);
    diff = up - dn;
    if (up < dn) begin
      res = '0;
    end else if (diff[SumW-1:prw_pkg::ChanW] != '0) begin
      res = '1;
    end else begin
      res = diff[prw_pkg::ChanW-1:0];
    end
    return res;
  endfunction

  assign edge_o.r = chan_edge(top0_i.r, top1_i.r, top2_i.r, bot0_i.r, bot1_i.r, bot2_i.r);
  assign edge_o.g = chan_edge(top0_i.g, top1_i.g, top2_i.g, bot0_i.g, bot1_i.g, bot2_i.g);
  assign edge_o.b = chan_edge(top0_i.b, top1_i.b, top2_i.b, bot0_i.b, bot1_i.b, bot2_i.b);

endmodule

>>> rtl/prw_line_ram.sv
// Single-clock line memory with one write port and one registered read port.
// Holds both buffered rows side by side in each entry. No dependencies.
module prw_line_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 48
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/prewitt_horizontal_edge_rgb_core.sv
// Horizontal Prewitt edge filter over an RGB raster stream, one pixel per
// input transaction. Results lag the input by one row and one column and pass
// the stage and output registers. The block sustains one input per cycle
// while each input causes at most one result and the output is not stalled.
// An input at the end of a row after the first causes two results, every
// input on the last row past column 0 causes two, and the final input of the
// frame causes four; since the single output register hands over one result
// per cycle when not stalled, the next input waits until each extra result
// is handed over. Both previous rows live in one line memory, read at
// acceptance and written back when the transaction retires, so no clearing
// pass follows reset. A configuration write restarts the frame at pixel (0,0)
// and must happen only while idle.
module prewitt_horizontal_edge_rgb_core #(
  parameter int unsigned MAX_WIDTH  = prw_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = prw_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  prw_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output prw_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [prw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [prw_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned LineW = 2 * prw_pkg::PixW;

  localparam int unsigned WidthResetEff =
    (prw_pkg::ImageWidthReset > MAX_WIDTH) ? MAX_WIDTH : prw_pkg::ImageWidthReset;
  localparam int unsigned HeightResetEff =
    (prw_pkg::ImageHeightReset > MAX_HEIGHT) ? MAX_HEIGHT : prw_pkg::ImageHeightReset;
  localparam logic [ColW-1:0] ColLastReset = ColW'(WidthResetEff - 1);
  localparam logic [RowW-1:0] RowLastReset = RowW'(HeightResetEff - 1);

  typedef struct packed {
    prw_pkg::pix_t   cur;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            emit;
    logic            interior;
    logic            last_row;
    logic            last_col;
  } item_t;

  // Frame geometry, stored as last column and last row index.
  logic [ColW-1:0] col_last_q, col_last_d;
  logic [RowW-1:0] row_last_q, row_last_d;
  logic            restart;

  always_comb begin
    int unsigned wv;
    int unsigned hv;
    wv = 32'(cfg_data_i[prw_pkg::CfgWidthW-1:0]);
    hv = 32'(cfg_data_i[prw_pkg::CfgHeightW-1:0]);
    if (wv < prw_pkg::DimMin) wv = prw_pkg::DimMin;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < prw_pkg::DimMin) hv = prw_pkg::DimMin;
    if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    restart    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        prw_pkg::CFG_IMAGE_WIDTH: begin
          col_last_d = ColW'(wv - 1);
          restart    = 1'b1;
        end
        prw_pkg::CFG_IMAGE_HEIGHT: begin
          row_last_d = RowW'(hv - 1);
          restart    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Position of the next input pixel.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_q == col_last_q) begin
        col_d = '0;
        row_d = (row_q == row_last_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Stage holding the accepted pixel while its line entry is read and its
  // results are handed to the output register.
  item_t           s1_q, s1_d;
  logic            s1_valid_q, s1_valid_d;
  prw_pkg::slot_e  slot_q, slot_d, slot_nxt;
  logic            slot_is_last;
  logic            out_free;
  logic            emit_now;
  logic            retire;

  always_comb begin
    s1_d.cur      = in_data_i;
    s1_d.col      = col_q;
    s1_d.row      = row_q;
    s1_d.emit     = (row_q != '0) && (col_q != '0);
    s1_d.interior = (row_q > RowW'(1)) && (col_q > ColW'(1));
    s1_d.last_row = (row_q == row_last_q);
    s1_d.last_col = (col_q == col_last_q);
  end

  always_comb begin
    slot_nxt     = slot_q;
    slot_is_last = 1'b1;
    case (slot_q)
      prw_pkg::SLOT_CENTER: begin
        if (s1_q.last_row) begin
          slot_nxt     = prw_pkg::SLOT_BELOW;
          slot_is_last = 1'b0;
        end else if (s1_q.last_col) begin
          slot_nxt     = prw_pkg::SLOT_RIGHT;
          slot_is_last = 1'b0;
        end
      end
      prw_pkg::SLOT_BELOW: begin
        if (s1_q.last_col) begin
          slot_nxt     = prw_pkg::SLOT_RIGHT;
          slot_is_last = 1'b0;
        end
      end
      prw_pkg::SLOT_RIGHT: begin
        if (s1_q.last_row) begin
          slot_nxt     = prw_pkg::SLOT_CORNER;
          slot_is_last = 1'b0;
        end
      end
      prw_pkg::SLOT_CORNER: ;
      default: ;
    endcase
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign emit_now   = s1_valid_q && s1_q.emit && out_free;
  assign retire     = s1_valid_q && (!s1_q.emit || (out_free && slot_is_last));
  assign in_ready_o = !s1_valid_q || retire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    slot_d     = slot_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      slot_d     = prw_pkg::SLOT_CENTER;
    end else if (retire) begin
      s1_valid_d = 1'b0;
    end else if (emit_now) begin
      slot_d = slot_nxt;
    end
  end

  // Line memory: each entry holds {row two above, row just above}.
  logic [LineW-1:0] line_rd;
  prw_pkg::pix_t    up_pix;
  prw_pkg::pix_t    mid_pix;

  assign up_pix  = line_rd[LineW-1:prw_pkg::PixW];
  assign mid_pix = line_rd[prw_pkg::PixW-1:0];

  prw_line_ram #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW),
    .DataW (LineW)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (retire),
    .wr_addr_i (s1_q.col),
    .wr_data_i ({mid_pix, s1_q.cur})
  );

  // Columns col-2 and col-1 of the upper and current rows, and col-1 of the
  // middle row, as seen by the pixel in the stage.
  prw_pkg::pix_t up_m2_q, up_m1_q, mid_m1_q, cur_m2_q, cur_m1_q;
  prw_pkg::pix_t edge_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_m2_q  <= '0;
      up_m1_q  <= '0;
      mid_m1_q <= '0;
      cur_m2_q <= '0;
      cur_m1_q <= '0;
    end else if (restart) begin
      up_m2_q  <= '0;
      up_m1_q  <= '0;
      mid_m1_q <= '0;
      cur_m2_q <= '0;
      cur_m1_q <= '0;
    end else if (retire) begin
      up_m2_q  <= up_m1_q;
      up_m1_q  <= up_pix;
      mid_m1_q <= mid_pix;
      cur_m2_q <= cur_m1_q;
      cur_m1_q <= s1_q.cur;
    end
  end

  prw_edge u_edge (
    .top0_i (up_m2_q),
    .top1_i (up_m1_q),
    .top2_i (up_pix),
    .bot0_i (cur_m2_q),
    .bot1_i (cur_m1_q),
    .bot2_i (s1_q.cur),
    .edge_o (edge_pix)
  );

  // Select the result of the current slot.
  prw_pkg::pix_t   res_pix;
  logic [ColW-1:0] res_col;
  logic [RowW-1:0] res_row;
  logic [ColW+prw_pkg::OutColW-1:0] res_col_ext;
  logic [RowW+prw_pkg::OutRowW-1:0] res_row_ext;
  prw_pkg::out_t   out_d, out_q;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    res_pix = s1_q.cur;
    res_col = s1_q.col;
    res_row = s1_q.row;
    case (slot_q)
      prw_pkg::SLOT_CENTER: begin
        res_pix = s1_q.interior ? edge_pix : mid_m1_q;
        res_col = s1_q.col - ColW'(1);
        res_row = s1_q.row - RowW'(1);
      end
      prw_pkg::SLOT_BELOW: begin
        res_pix = cur_m1_q;
        res_col = s1_q.col - ColW'(1);
      end
      prw_pkg::SLOT_RIGHT: begin
        res_pix = mid_pix;
        res_row = s1_q.row - RowW'(1);
      end
      prw_pkg::SLOT_CORNER: ;
      default: ;
    endcase
  end

  assign res_col_ext = {{prw_pkg::OutColW{1'b0}}, res_col};
  assign res_row_ext = {{prw_pkg::OutRowW{1'b0}}, res_row};

  always_comb begin
    out_d.out_red   = res_pix.r;
    out_d.out_green = res_pix.g;
    out_d.out_blue  = res_pix.b;
    out_d.out_col   = res_col_ext[prw_pkg::OutColW-1:0];
    out_d.out_row   = res_row_ext[prw_pkg::OutRowW-1:0];
    out_d.run_end   = slot_is_last;
    out_d.frame_end = (slot_q == prw_pkg::SLOT_CORNER);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_now) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q  <= ColLastReset;
      row_last_q  <= RowLastReset;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      slot_q      <= prw_pkg::SLOT_CENTER;
      out_valid_q <= 1'b0;
    end else begin
      col_last_q  <= col_last_d;
      row_last_q  <= row_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    if (emit_now) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
